/* rtl/kes_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kes_pkg
// Shared types and constants for the key event scanner.
// ----------------------------------------------------------------------------
package kes_pkg;

    localparam int KEY_LANES        = 8;
    localparam int TICK_W           = 16;
    localparam int NUM_KEYS_DEF     = 8;
    localparam int COUNTER_BITS_DEF = 16;
    localparam int QUEUE_DEPTH      = 2;
    localparam int CFG_IDX_W        = 2;
    localparam int OUT_W            = 4 * KEY_LANES;

    localparam logic [TICK_W-1:0] LONG_PRESS_RST   = 16'd20;
    localparam logic [TICK_W-1:0] REPEAT_START_RST = 16'd10;
    localparam logic [TICK_W-1:0] REPEAT_PERIOD_RST = 16'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LONG_PRESS    = 2'd0,
        REG_REPEAT_START  = 2'd1,
        REG_REPEAT_PERIOD = 2'd2
    } kes_reg_idx_t;

    typedef struct packed {
        logic [TICK_W-1:0] long_press_ticks;
        logic [TICK_W-1:0] repeat_start_ticks;
        logic [TICK_W-1:0] repeat_period_ticks;
    } kes_cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } kes_state_t;

endpackage : kes_pkg
`default_nettype wire

/* rtl/key_event_scanner.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// key_event_scanner
// Keypad scanner with press, release, long-press and auto-repeat events.
// ----------------------------------------------------------------------------
// Each input item is one poll tick with the raw active-low levels of the
// keys; each tick yields exactly one output item with four event masks.
// In the scan engine a tick is popped and bumps the shared counters, the
// min(NUM_KEYS, 8) keys are scanned one key per cycle in index order through
// a single key unit, and the output register is loaded. Up to two ticks
// wait in the input queue while the engine is busy or the output stalls.
// Write the tick registers only while the block is idle.
// ----------------------------------------------------------------------------
module key_event_scanner
#(
    parameter int NUM_KEYS     = kes_pkg::NUM_KEYS_DEF,
    parameter int COUNTER_BITS = kes_pkg::COUNTER_BITS_DEF
)
(
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire  [kes_pkg::KEY_LANES-1:0]  s_axis_tdata,   // key_levels
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    // press_events, release_events, long_press_events, repeat_events
    output logic [kes_pkg::OUT_W-1:0]      m_axis_tdata,
    input  wire                            cfg_we,
    input  wire  [kes_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [kes_pkg::TICK_W-1:0]     cfg_wdata
);
    import kes_pkg::*;

    kes_cfg_t             cfg_reg;
    logic                 q_valid;
    logic                 q_pop;
    logic [KEY_LANES-1:0] q_data;
    logic [KEY_LANES-1:0] press_events;
    logic [KEY_LANES-1:0] release_events;
    logic [KEY_LANES-1:0] long_press_events;
    logic [KEY_LANES-1:0] repeat_events;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks    <= LONG_PRESS_RST;
            cfg_reg.repeat_start_ticks  <= REPEAT_START_RST;
            cfg_reg.repeat_period_ticks <= REPEAT_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LONG_PRESS:    cfg_reg.long_press_ticks    <= cfg_wdata;
                REG_REPEAT_START:  cfg_reg.repeat_start_ticks  <= cfg_wdata;
                REG_REPEAT_PERIOD: cfg_reg.repeat_period_ticks <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    kes_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (s_axis_tvalid),
        .wr_ready (s_axis_tready),
        .wr_data  (s_axis_tdata),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_data  (q_data)
    );

    kes_engine
    #(
        .NUM_KEYS     (NUM_KEYS),
        .COUNTER_BITS (COUNTER_BITS)
    )
    u_engine
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .q_valid           (q_valid),
        .q_pop             (q_pop),
        .q_data            (q_data),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .press_events      (press_events),
        .release_events    (release_events),
        .long_press_events (long_press_events),
        .repeat_events     (repeat_events)
    );

    assign m_axis_tdata = {repeat_events, long_press_events, release_events, press_events};

endmodule : key_event_scanner
`default_nettype wire

/* rtl/kes_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kes_queue
// Front end: accepts poll items and holds them in a short queue for the
// scan engine.
// ----------------------------------------------------------------------------
module kes_queue
(
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            wr_valid,
    output logic                           wr_ready,
    input  wire  [kes_pkg::KEY_LANES-1:0]  wr_data,
    output logic                           rd_valid,
    input  wire                            rd_pop,
    output logic [kes_pkg::KEY_LANES-1:0]  rd_data
);
    import kes_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [KEY_LANES-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 push;
    logic                 pop;

    assign wr_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule : kes_queue
`default_nettype wire

/* rtl/kes_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kes_engine
// Back end: bumps the shared tick counters, scans one key per cycle and
// hands the four event masks to an output register.
// ----------------------------------------------------------------------------
module kes_engine
#(
    parameter int NUM_KEYS     = kes_pkg::NUM_KEYS_DEF,
    parameter int COUNTER_BITS = kes_pkg::COUNTER_BITS_DEF
)
(
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire  kes_pkg::kes_cfg_t        cfg,
    input  wire                            q_valid,
    output logic                           q_pop,
    input  wire  [kes_pkg::KEY_LANES-1:0]  q_data,
    output logic                           out_valid,
    input  wire                            out_ready,
    output logic [kes_pkg::KEY_LANES-1:0]  press_events,
    output logic [kes_pkg::KEY_LANES-1:0]  release_events,
    output logic [kes_pkg::KEY_LANES-1:0]  long_press_events,
    output logic [kes_pkg::KEY_LANES-1:0]  repeat_events
);
    import kes_pkg::*;

    localparam int SCAN_KEYS = (NUM_KEYS < KEY_LANES) ? NUM_KEYS : KEY_LANES;
    localparam int IDX_W     = (SCAN_KEYS > 1) ? $clog2(SCAN_KEYS) : 1;
    localparam int CMP_W     = (COUNTER_BITS > TICK_W) ? COUNTER_BITS : TICK_W;
    localparam logic [COUNTER_BITS-1:0] CTR_TOP = '1;

    kes_state_t             state_reg, state_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [SCAN_KEYS-1:0]    lev_reg, lev_next;
    logic [SCAN_KEYS-1:0]    held_reg, held_next;
    logic [SCAN_KEYS-1:0]    long_reg, long_next;
    logic [SCAN_KEYS-1:0]    rep_reg, rep_next;
    logic [COUNTER_BITS-1:0] long_cnt_reg, long_cnt_next;
    logic [COUNTER_BITS-1:0] rep_cnt_reg, rep_cnt_next;
    logic [SCAN_KEYS-1:0]    ev_press_reg, ev_press_next;
    logic [SCAN_KEYS-1:0]    ev_rel_reg, ev_rel_next;
    logic [SCAN_KEYS-1:0]    ev_long_reg, ev_long_next;
    logic [SCAN_KEYS-1:0]    ev_rep_reg, ev_rep_next;
    logic                    out_valid_reg, out_valid_next;
    logic [SCAN_KEYS-1:0]    o_press_reg, o_press_next;
    logic [SCAN_KEYS-1:0]    o_rel_reg, o_rel_next;
    logic [SCAN_KEYS-1:0]    o_long_reg, o_long_next;
    logic [SCAN_KEYS-1:0]    o_rep_reg, o_rep_next;

    logic key_now;
    logic key_held;
    logic long_hit;
    logic start_hit;
    logic period_hit;

    assign key_now    = ~lev_reg[idx_reg];
    assign key_held   = held_reg[idx_reg];
    assign long_hit   = CMP_W'(long_cnt_reg) >= CMP_W'(cfg.long_press_ticks);
    assign start_hit  = CMP_W'(rep_cnt_reg) >= CMP_W'(cfg.repeat_start_ticks);
    assign period_hit = CMP_W'(rep_cnt_reg) >= CMP_W'(cfg.repeat_period_ticks);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        lev_next       = lev_reg;
        held_next      = held_reg;
        long_next      = long_reg;
        rep_next       = rep_reg;
        long_cnt_next  = long_cnt_reg;
        rep_cnt_next   = rep_cnt_reg;
        ev_press_next  = ev_press_reg;
        ev_rel_next    = ev_rel_reg;
        ev_long_next   = ev_long_reg;
        ev_rep_next    = ev_rep_reg;
        out_valid_next = out_valid_reg && !out_ready;
        o_press_next   = o_press_reg;
        o_rel_next     = o_rel_reg;
        o_long_next    = o_long_reg;
        o_rep_next     = o_rep_reg;
        q_pop          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop         = 1'b1;
                    lev_next      = q_data[SCAN_KEYS-1:0];
                    long_cnt_next = (long_cnt_reg == CTR_TOP) ? CTR_TOP : long_cnt_reg + 1'b1;
                    rep_cnt_next  = (rep_cnt_reg == CTR_TOP) ? CTR_TOP : rep_cnt_reg + 1'b1;
                    idx_next      = '0;
                    ev_press_next = '0;
                    ev_rel_next   = '0;
                    ev_long_next  = '0;
                    ev_rep_next   = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (key_now && !key_held)
                begin
                    held_next[idx_reg]     = 1'b1;
                    long_next[idx_reg]     = 1'b0;
                    rep_next[idx_reg]      = 1'b0;
                    ev_press_next[idx_reg] = 1'b1;
                    long_cnt_next          = '0;
                    rep_cnt_next           = '0;
                end
                else if (!key_now && key_held)
                begin
                    held_next[idx_reg] = 1'b0;
                    if (!long_reg[idx_reg])
                    begin
                        ev_rel_next[idx_reg] = 1'b1;
                    end
                end
                else if (key_now && key_held)
                begin
                    if (!long_reg[idx_reg] && long_hit)
                    begin
                        long_next[idx_reg]    = 1'b1;
                        ev_long_next[idx_reg] = 1'b1;
                        long_cnt_next         = '0;
                    end
                    if (!rep_reg[idx_reg])
                    begin
                        if (start_hit)
                        begin
                            rep_next[idx_reg]    = 1'b1;
                            ev_rep_next[idx_reg] = 1'b1;
                            rep_cnt_next         = '0;
                        end
                    end
                    else if (period_hit)
                    begin
                        ev_rep_next[idx_reg] = 1'b1;
                        rep_cnt_next         = '0;
                    end
                end
                if (idx_reg == IDX_W'(SCAN_KEYS - 1))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    o_press_next   = ev_press_reg;
                    o_rel_next     = ev_rel_reg;
                    o_long_next    = ev_long_reg;
                    o_rep_next     = ev_rep_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_reg      <= '0;
            long_reg      <= '0;
            rep_reg       <= '0;
            long_cnt_reg  <= '0;
            rep_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            long_reg      <= long_next;
            rep_reg       <= rep_next;
            long_cnt_reg  <= long_cnt_next;
            rep_cnt_reg   <= rep_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        lev_reg      <= lev_next;
        ev_press_reg <= ev_press_next;
        ev_rel_reg   <= ev_rel_next;
        ev_long_reg  <= ev_long_next;
        ev_rep_reg   <= ev_rep_next;
        o_press_reg  <= o_press_next;
        o_rel_reg    <= o_rel_next;
        o_long_reg   <= o_long_next;
        o_rep_reg    <= o_rep_next;
    end

    assign out_valid         = out_valid_reg;
    assign press_events      = KEY_LANES'(o_press_reg);
    assign release_events    = KEY_LANES'(o_rel_reg);
    assign long_press_events = KEY_LANES'(o_long_reg);
    assign repeat_events     = KEY_LANES'(o_rep_reg);

endmodule : kes_engine
`default_nettype wire
